@@ sv/lwpcs_pkg.sv @@
// Shared types, constants and step codes for the LCD window and pixel command stream.
package lwpcs_pkg;

  localparam int unsigned CoordW = 16;
  localparam int unsigned ColorW = 16;
  localparam int unsigned CmdW   = 2;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned StepW  = 4;

  localparam int unsigned PANEL_WIDTH_DEF  = 240;
  localparam int unsigned PANEL_HEIGHT_DEF = 320;

  // Command codes on the input channel.
  localparam logic [CmdW-1:0] CMD_WINDOW = 2'd0;
  localparam logic [CmdW-1:0] CMD_PIXEL  = 2'd1;
  localparam logic [CmdW-1:0] CMD_STREAM = 2'd2;

  // Controller opcodes.
  localparam logic [ByteW-1:0] OP_COLUMN_SET   = 8'h2A;
  localparam logic [ByteW-1:0] OP_ROW_SET      = 8'h2B;
  localparam logic [ByteW-1:0] OP_MEMORY_WRITE = 8'h2C;
  localparam logic [ByteW-1:0] BYTE_MASK       = 8'hFF;

  // Position of each byte within the full thirteen-byte pixel sequence.
  localparam logic [StepW-1:0] STEP_COL_OP    = 4'd0;
  localparam logic [StepW-1:0] STEP_XS_HI     = 4'd1;
  localparam logic [StepW-1:0] STEP_XS_LO     = 4'd2;
  localparam logic [StepW-1:0] STEP_XE_HI     = 4'd3;
  localparam logic [StepW-1:0] STEP_XE_LO     = 4'd4;
  localparam logic [StepW-1:0] STEP_ROW_OP    = 4'd5;
  localparam logic [StepW-1:0] STEP_YS_HI     = 4'd6;
  localparam logic [StepW-1:0] STEP_YS_LO     = 4'd7;
  localparam logic [StepW-1:0] STEP_YE_HI     = 4'd8;
  localparam logic [StepW-1:0] STEP_YE_LO     = 4'd9;
  localparam logic [StepW-1:0] STEP_MEMWR_OP  = 4'd10;
  localparam logic [StepW-1:0] STEP_COLOR_HI  = 4'd11;
  localparam logic [StepW-1:0] STEP_COLOR_LO  = 4'd12;

  typedef struct packed {
    logic [CmdW-1:0]   command;
    logic [CoordW-1:0] x_start;
    logic [CoordW-1:0] y_start;
    logic [CoordW-1:0] x_end;
    logic [CoordW-1:0] y_end;
    logic [ColorW-1:0] color;
  } item_t;

  typedef struct packed {
    logic [ByteW-1:0] value;
    logic             is_data;
  } byte_t;

  typedef struct packed {
    logic             busy;
    logic [StepW-1:0] step;
  } seq_status_t;

endpackage

@@ sv/lwpcs_byte_sel.sv @@
// Byte selector that picks the opcode or field byte for the current sequence step.
module lwpcs_byte_sel (
  input  lwpcs_pkg::item_t      held_item,
  input  logic [3:0]            step,
  output lwpcs_pkg::byte_t      sel_byte
);
  import lwpcs_pkg::*;

  always_comb begin
    sel_byte = '{value: OP_COLUMN_SET, is_data: 1'b0};
    case (step)
      STEP_COL_OP:   sel_byte = '{value: OP_COLUMN_SET, is_data: 1'b0};
      STEP_XS_HI:    sel_byte = '{value: held_item.x_start[15:8], is_data: 1'b1};
      STEP_XS_LO:    sel_byte = '{value: held_item.x_start[7:0] & BYTE_MASK, is_data: 1'b1};
      STEP_XE_HI:    sel_byte = '{value: held_item.x_end[15:8], is_data: 1'b1};
      STEP_XE_LO:    sel_byte = '{value: held_item.x_end[7:0], is_data: 1'b1};
      STEP_ROW_OP:   sel_byte = '{value: OP_ROW_SET, is_data: 1'b0};
      STEP_YS_HI:    sel_byte = '{value: held_item.y_start[15:8], is_data: 1'b1};
      STEP_YS_LO:    sel_byte = '{value: held_item.y_start[7:0], is_data: 1'b1};
      STEP_YE_HI:    sel_byte = '{value: held_item.y_end[15:8], is_data: 1'b1};
      STEP_YE_LO:    sel_byte = '{value: held_item.y_end[7:0], is_data: 1'b1};
      STEP_MEMWR_OP: sel_byte = '{value: OP_MEMORY_WRITE, is_data: 1'b0};
      STEP_COLOR_HI: sel_byte = '{value: held_item.color[15:8], is_data: 1'b1};
      STEP_COLOR_LO: sel_byte = '{value: held_item.color[7:0], is_data: 1'b1};
      default:       sel_byte = '{value: OP_COLUMN_SET, is_data: 1'b0};
    endcase
  end

endmodule

@@ sv/lwpcs_seq.sv @@
// Sequencer that holds the current item, walks the byte steps and drives the output register.
module lwpcs_seq #(
  parameter int unsigned PANEL_WIDTH  = lwpcs_pkg::PANEL_WIDTH_DEF,
  parameter int unsigned PANEL_HEIGHT = lwpcs_pkg::PANEL_HEIGHT_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  input  lwpcs_pkg::item_t        in_item,
  input  lwpcs_pkg::byte_t        sel_byte,
  input  logic                    out_stall,
  output lwpcs_pkg::item_t        held_item,
  output lwpcs_pkg::seq_status_t  status,
  output logic                    out_valid,
  output lwpcs_pkg::byte_t        out_data,
  output logic                    out_last
);
  import lwpcs_pkg::*;

  logic             busy_r, busy_nxt;
  logic [StepW-1:0] step_r, step_nxt;
  logic [StepW-1:0] end_r, end_nxt;
  item_t            item_r, item_nxt;
  logic             out_valid_r, out_valid_nxt;
  byte_t            out_data_r, out_data_nxt;
  logic             out_last_r, out_last_nxt;

  logic             out_free;
  logic             in_panel;
  logic             at_end;

  assign out_free = !out_valid_r || !out_stall;
  assign in_panel = ({1'b0, in_item.x_start} < (CoordW+1)'(PANEL_WIDTH)) &&
                    ({1'b0, in_item.y_start} < (CoordW+1)'(PANEL_HEIGHT));
  assign at_end   = (step_r == end_r);

  always_comb begin
    busy_nxt      = busy_r;
    step_nxt      = step_r;
    end_nxt       = end_r;
    item_nxt      = item_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;

    if (out_free) begin
      out_valid_nxt = busy_r;
    end

    if (busy_r) begin
      if (out_free) begin
        out_data_nxt = sel_byte;
        out_last_nxt = at_end;
        if (at_end) begin
          busy_nxt = 1'b0;
        end else begin
          step_nxt = step_r + 4'd1;
        end
      end
    end else if (in_valid) begin
      item_nxt = in_item;
      // A single pixel is a one-pixel window, so the end corner is the start corner.
      if (in_item.command == CMD_PIXEL) begin
        item_nxt.x_end = in_item.x_start;
        item_nxt.y_end = in_item.y_start;
      end
      case (in_item.command)
        CMD_WINDOW: begin
          busy_nxt = 1'b1;
          step_nxt = STEP_COL_OP;
          end_nxt  = STEP_MEMWR_OP;
        end
        CMD_PIXEL: begin
          busy_nxt = in_panel;
          step_nxt = STEP_COL_OP;
          end_nxt  = STEP_COLOR_LO;
        end
        CMD_STREAM: begin
          busy_nxt = 1'b1;
          step_nxt = STEP_COLOR_HI;
          end_nxt  = STEP_COLOR_LO;
        end
        default: begin
          busy_nxt = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      step_r      <= '0;
      end_r       <= '0;
      item_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      step_r      <= step_nxt;
      end_r       <= end_nxt;
      item_r      <= item_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
  end

  assign held_item   = item_r;
  assign status.busy = busy_r;
  assign status.step = step_r;
  assign out_valid   = out_valid_r;
  assign out_data    = out_data_r;
  assign out_last    = out_last_r;

endmodule

@@ sv/lcd_window_pixel_command_stream_core.sv @@
// Top level of the LCD window and pixel command stream generator.
//
// The block turns drawing requests into the byte stream of a serial LCD
// controller. Each input beat carries a command with window corners and a
// color. Set window yields eleven beats (column set, four coordinate bytes,
// row set, four coordinate bytes, memory write). Draw pixel yields thirteen
// beats (a one-pixel window and the two color bytes), or none when the pixel
// lies outside the panel. Stream color yields the two color bytes. The
// unused command code yields nothing. Every result beat carries the byte,
// a data flag (low for an opcode) and a last flag on the final beat.
// One byte selector serves all steps under a small step counter, so the
// block emits one byte per cycle while the receiver does not stall. The
// input is stalled while an item is being emitted. When the receiver
// stalls, the output register holds its beat and the step counter waits.
// Reset clears the sequencer and the output valid flag; no beat is
// pending afterwards.
module lcd_window_pixel_command_stream_core #(
  parameter int unsigned PANEL_WIDTH  = lwpcs_pkg::PANEL_WIDTH_DEF,
  parameter int unsigned PANEL_HEIGHT = lwpcs_pkg::PANEL_HEIGHT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_command,
  input  logic [15:0] in_x_start,
  input  logic [15:0] in_y_start,
  input  logic [15:0] in_x_end,
  input  logic [15:0] in_y_end,
  input  logic [15:0] in_color,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        out_is_data,
  output logic        out_last
);
  import lwpcs_pkg::*;

  item_t       in_item;
  item_t       held_item;
  seq_status_t status;
  byte_t       sel_byte;
  byte_t       out_data;

  assign in_item = '{command: in_command, x_start: in_x_start, y_start: in_y_start,
                     x_end: in_x_end, y_end: in_y_end, color: in_color};

  lwpcs_seq #(
    .PANEL_WIDTH  (PANEL_WIDTH),
    .PANEL_HEIGHT (PANEL_HEIGHT)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_item   (in_item),
    .sel_byte  (sel_byte),
    .out_stall (out_stall),
    .held_item (held_item),
    .status    (status),
    .out_valid (out_valid),
    .out_data  (out_data),
    .out_last  (out_last)
  );

  lwpcs_byte_sel u_byte_sel (
    .held_item (held_item),
    .step      (status.step),
    .sel_byte  (sel_byte)
  );

  // New items are taken only when no byte sequence is in flight.
  assign in_stall    = status.busy;
  assign out_byte    = out_data.value;
  assign out_is_data = out_data.is_data;

  // A pending beat that is not the last one means the sequencer still owns the item.
  a_nonlast_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last) |-> status.busy)
    else $error("non-last beat pending while sequencer idle");

  // The step counter never runs past the color low byte.
  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    status.busy |-> (status.step <= STEP_COLOR_LO))
    else $error("step counter out of range");

  // A stream color item starts at the color high byte.
  a_stream_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && (in_command == CMD_STREAM)) |=>
      (status.busy && (status.step == STEP_COLOR_HI)))
    else $error("stream color did not start at the color byte");

  // A window item always starts at the column set opcode.
  a_window_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && (in_command == CMD_WINDOW)) |=>
      (status.busy && (status.step == STEP_COL_OP)))
    else $error("set window did not start at the column opcode");

endmodule
